@@ rtl/core/stable_priority_queue_macros.svh @@
// ---------------------------------------------------------------------------
// stable_priority_queue_macros.svh
// assertion macros shared by the priority queue rtl
// ---------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// checked property, off while reset is high
`define SPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// checked property, active during reset too
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SPQ_ASSERT(label, clk, rst, prop, msg)
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ rtl/core/spq_pkg.sv @@
// ---------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the stable priority queue
// ---------------------------------------------------------------------------
`default_nettype none
package spq_pkg;

   // default number of queue entries
   localparam int SPQ_DEPTH = 16;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   // one stored entry
   typedef struct packed {
      logic [7:0]         prio;
      logic signed [31:0] value;
   } entry_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RM_WAIT,
      ST_INS_RD,
      ST_INS_CMP,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

@@ rtl/core/spq_ram.sv @@
// ---------------------------------------------------------------------------
// spq_ram
// entry store: one write port, one read port with registered read data
// ---------------------------------------------------------------------------
`default_nettype none
module spq_ram #(
   parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH,
   localparam int AW = $clog2(QUEUE_DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire spq_pkg::entry_type wr_data,
   input  wire logic [AW-1:0]      rd_addr,
   output spq_pkg::entry_type      rd_data
);
   import spq_pkg::*;

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/stable_priority_queue.sv @@
// Remove: the head read issued in idle is captured in ST_RM_WAIT, then ST_FINISH loads the result;
// underflow and overflow go straight to ST_FINISH. Insert: ST_INS_RD reads the next entry toward the
// head and ST_INS_CMP moves it back one slot while its priority is higher, walking from the tail toward
// the head until the new word is written. One word at a time: ready rises as the result is loaded,
// and a result still waiting holds the next word off.
// Synchronous reset empties the queue; the store itself is not cleared.
// ---------------------------------------------------------------------------
// stable_priority_queue
// bounded sorted priority queue in a circular store, ties in arrival order
// ---------------------------------------------------------------------------
`default_nettype none
`include "stable_priority_queue_macros.svh"
module stable_priority_queue #(
   parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_cmd,
   input  wire logic signed [31:0] req_item_value,
   input  wire logic [7:0]         req_item_priority,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_out_value,
   output logic [7:0]              rsp_out_priority,
   output logic [4:0]              rsp_occupancy
);
   import spq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

   state_type state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [CW-1:0] left_ff, left_in;
   entry_type     new_ff, new_in;
   logic [1:0]    res_status_ff, res_status_in;
   entry_type     res_entry_ff, res_entry_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   entry_type     rsp_entry_ff, rsp_entry_in;
   logic [4:0]    rsp_occ_ff, rsp_occ_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;
   logic [AW-1:0] cur_prev;

   // circular index helpers
   function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + AW'(1);
   endfunction

   function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] idx);
      return (idx == '0) ? LAST_IDX : idx - AW'(1);
   endfunction

   spq_ram #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign cur_prev = idx_prev(cur_ff);

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      left_ff       <= left_in;
      new_ff        <= new_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // sequencer: next state, store access and result capture
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      left_in       = left_ff;
      new_in        = new_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      req_ready     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = new_ff;
      rd_addr       = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_status_in = STATUS_OK;
               res_entry_in  = '0;
               new_in.value  = req_item_value;
               new_in.prio   = req_item_priority;
               cur_in        = tail_ff;
               left_in       = count_ff;
               if (req_cmd) begin
                  // remove: head read is already in flight
                  if (count_ff == '0) begin
                     res_status_in = STATUS_UNDERFLOW;
                     state_in      = ST_FINISH;
                  end else begin
                     state_in = ST_RM_WAIT;
                  end
               end else begin
                  if (count_ff == FULL_CNT) begin
                     res_status_in = STATUS_OVERFLOW;
                     state_in      = ST_FINISH;
                  end else begin
                     state_in = ST_INS_RD;
                  end
               end
            end
         end
         ST_RM_WAIT: begin
            res_entry_in = rd_data;
            head_in      = idx_next(head_ff);
            count_in     = count_ff - CW'(1);
            state_in     = ST_FINISH;
         end
         ST_INS_RD: begin
            if (left_ff == '0) begin
               // reached the head: place the new word here
               wr_en    = 1'b1;
               tail_in  = idx_next(tail_ff);
               count_in = count_ff + CW'(1);
               state_in = ST_FINISH;
            end else begin
               rd_addr  = cur_prev;
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            wr_en = 1'b1;
            if (rd_data.prio > new_ff.prio) begin
               // move the older entry back one slot
               wr_data  = rd_data;
               cur_in   = cur_prev;
               left_in  = left_ff - CW'(1);
               state_in = ST_INS_RD;
            end else begin
               tail_in  = idx_next(tail_ff);
               count_in = count_ff + CW'(1);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_occ_in    = 5'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result port
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_value    = rsp_entry_ff.value;
   assign rsp_out_priority = rsp_entry_ff.prio;
   assign rsp_occupancy    = rsp_occ_ff;

   // checks
   `SPQ_ASSERT(a_count_bound, clock, reset, count_ff <= FULL_CNT, "count above depth")
   `SPQ_ASSERT(a_empty_ptrs, clock, reset, (count_ff == '0) |-> (head_ff == tail_ff), "empty queue with pointers apart")
   `SPQ_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> (state_ff != ST_IDLE), "idle right after accept")
   `SPQ_ASSERT(a_underflow_empty, clock, reset, ((state_ff == ST_FINISH) && (res_status_ff == STATUS_UNDERFLOW)) |-> (count_ff == '0), "underflow with entries held")

endmodule
`default_nettype wire
